/* rtl/jued_pkg.sv */
// Package for the JSON \uXXXX escape decoder.
// Byte constants, phase encoding, queue command type and helper functions.
// No dependencies.
package jued_pkg;

    localparam logic [7:0] BSL_BYTE  = 8'h5C;
    localparam logic [7:0] U_BYTE    = 8'h75;
    localparam int         MAX_UNITS = 6;
    localparam int         HELD_CNT  = 3;

    // escape progress; codes 6 and 7 never occur and fall back to idle
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_U    = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_D3   = 3'd5
    } t_phase;

    typedef logic [7:0]  t_held [HELD_CNT];

    // all code units caused by one input byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [2:0]                 cnt;
        logic                       last;
    } t_cmd;

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // j-th literal of a held escape prefix: backslash, 'u', digit bytes
    function automatic logic [15:0] lit_at(input logic [2:0] j, input t_held h);
        logic [15:0] r;
        case (j)
            3'd0:    r = {8'h00, BSL_BYTE};
            3'd1:    r = {8'h00, U_BYTE};
            3'd2:    r = {8'h00, h[0]};
            3'd3:    r = {8'h00, h[1]};
            3'd4:    r = {8'h00, h[2]};
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

/* rtl/jued_in_if.sv */
// Input byte channel: valid/ready handshake with byte and end-of-string mark.
// Depends on nothing.
interface jued_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/jued_out_if.sv */
// Output code unit channel: valid/ready handshake with 16-bit unit and mark.
// Depends on nothing.
interface jued_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        out_last;

    modport source (output valid, output code_unit, output out_last, input ready);
    modport sink   (input valid, input code_unit, input out_last, output ready);
endinterface

/* rtl/jued_front.sv */
// Front end: tracks escape phase, classifies each byte and builds a command
// listing every code unit it causes. Depends on jued_pkg, jued_in_if.
module jued_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    jued_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output jued_pkg::t_cmd  o_cmd
);
    import jued_pkg::*;

    t_phase      r_phase, n_phase;
    logic [11:0] r_acc, n_acc;
    t_held       r_held, n_held;

    logic [2:0]  n_a;       // literals flushed from the old prefix
    logic        x_vld;     // single unit for the byte itself
    logic [15:0] x_val;
    logic [2:0]  n_b;       // literals flushed at end of string
    logic [4:0]  hv;
    logic [2:0]  rel;
    logic        do_idle;
    logic        take;
    t_phase      mid_phase;

    assign i_in.ready = !i_full;
    assign take       = i_in.valid && !i_full;

    always_comb begin
        logic [2:0] j;
        j         = 3'd0;
        hv        = hex_val(i_in.in_byte);
        rel       = r_phase - PH_U;
        mid_phase = r_phase;
        n_acc     = r_acc;
        n_held    = r_held;
        n_a       = 3'd0;
        x_vld     = 1'b0;
        x_val     = 16'h0000;
        do_idle   = 1'b0;

        unique case (r_phase)
            PH_BSL: begin
                if (i_in.in_byte == U_BYTE) begin
                    mid_phase = PH_U;
                end else begin
                    n_a     = 3'd1;
                    do_idle = 1'b1;
                end
            end
            PH_U, PH_D1, PH_D2, PH_D3: begin
                if (!hv[4]) begin
                    n_a     = r_phase;
                    do_idle = 1'b1;
                end else if (r_phase == PH_D3) begin
                    x_vld     = 1'b1;
                    x_val     = {r_acc, hv[3:0]};
                    mid_phase = PH_IDLE;
                    n_acc     = 12'h000;
                end else begin
                    n_held[rel[1:0]] = i_in.in_byte;
                    n_acc            = {r_acc[7:0], hv[3:0]};
                    mid_phase        = t_phase'(r_phase + 3'd1);
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            mid_phase = PH_IDLE;
            n_acc     = 12'h000;
            if (i_in.in_byte == BSL_BYTE) begin
                mid_phase = PH_BSL;
            end else begin
                x_vld = 1'b1;
                x_val = {8'h00, i_in.in_byte};
            end
        end

        n_b     = i_in.in_last ? mid_phase : 3'd0;
        n_phase = i_in.in_last ? PH_IDLE : mid_phase;
        if (i_in.in_last) begin
            n_acc = 12'h000;
        end

        // old prefix first, then the byte's own unit, then the end flush
        for (int k = 0; k < MAX_UNITS; k++) begin
            j = 3'(k) - n_a - {2'b00, x_vld};
            if (3'(k) < n_a) begin
                o_cmd.units[k] = lit_at(3'(k), r_held);
            end else if (x_vld && 3'(k) == n_a) begin
                o_cmd.units[k] = x_val;
            end else begin
                o_cmd.units[k] = lit_at(j, n_held);
            end
        end
        o_cmd.cnt  = n_a + {2'b00, x_vld} + n_b;
        o_cmd.last = i_in.in_last;
    end

    assign o_push = take && (o_cmd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= 12'h000;
        end else if (take) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_held <= n_held;
        end
    end

endmodule

/* rtl/jued_queue.sv */
// Two-entry command queue between front and back end.
// Depends on jued_pkg.
module jued_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jued_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output jued_pkg::t_cmd  o_cmd
);
    import jued_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

/* rtl/jued_back.sv */
// Back end: walks the head command one code unit per transfer.
// Depends on jued_pkg, jued_out_if.
module jued_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jued_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    jued_out_if.source      o_out
);
    import jued_pkg::*;

    logic [2:0] r_idx;
    logic       at_end;

    assign at_end          = (r_idx == i_cmd.cnt - 3'd1);
    assign o_out.valid     = i_valid;
    assign o_out.code_unit = i_cmd.units[r_idx];
    assign o_out.out_last  = i_cmd.last && at_end;
    assign o_pop           = i_valid && o_out.ready && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (i_valid && o_out.ready) begin
            r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule

/* rtl/json_unicode_escape_decoder_top.sv */
// JSON \uXXXX escape decoder. Takes one byte per transfer and emits 16-bit
// code units: a complete escape becomes one unit, other bytes pass through
// zero-extended, and a broken or truncated escape is replayed as literals.
// A byte is taken every cycle while the two-entry command queue has room;
// each byte yields zero to six units and the output side sends one unit per
// cycle while the output is ready, so a byte causing several units holds the
// output, and the input stalls only once the queue fills behind such a replay or an output stall.
// Depends on jued_pkg, jued_in_if, jued_out_if, jued_front, jued_queue, jued_back.
module json_unicode_escape_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jued_in_if.sink    i_in,
    jued_out_if.source o_out
);
    import jued_pkg::*;

    logic push, full, pop, q_valid;
    t_cmd push_cmd, head_cmd;

    jued_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    jued_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    jued_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
